// ===== sv/cds_pkg.sv =====
// ----------------------------------------------------------------------------
// cds_pkg: shared types and constants for the calendar date stepper
// Holds widths, operation and order codes, the sequencer state type and the
// calendar helper functions (leap rule on year mod 400, month length).
// ----------------------------------------------------------------------------
package cds_pkg;

  // Field widths
  localparam int YEAR_BITS  = 14;
  localparam int COUNT_BITS = 16;
  localparam int DAY_W      = 5;
  localparam int MONTH_W    = 4;
  localparam int OP_W       = 2;
  localparam int ORDER_W    = 2;
  localparam int MOD400_W   = 9;

  // Working accumulator: day plus count with a sign bit and headroom
  localparam int ACC_W = ((COUNT_BITS > YEAR_BITS) ? COUNT_BITS : YEAR_BITS) + 2;

  // Number of restoring steps that reduce a year modulo 400; the scan stays
  // short enough that 400 shifted up never leaves the positive int range
  function automatic int calc_mod_steps(input int yb);
    int s;
    s = 0;
    for (int i = 0; i < 16; i++) begin
      if ((400 << i) <= ((1 << yb) - 1)) s = i + 1;
    end
    return s;
  endfunction

  localparam int MOD_STEPS = calc_mod_steps(YEAR_BITS);
  localparam int K_W       = $clog2(MOD_STEPS);

  // Year residues mod 400
  localparam logic [MOD400_W-1:0] MOD_RESET = MOD400_W'(1900 % 400);
  localparam logic [MOD400_W-1:0] MOD_TOP   = MOD400_W'(((1 << YEAR_BITS) - 1) % 400);
  localparam logic [MOD400_W-1:0] MOD_LAST  = MOD400_W'(399);
  localparam logic [MOD400_W-1:0] MOD_100   = MOD400_W'(100);
  localparam logic [MOD400_W-1:0] MOD_200   = MOD400_W'(200);
  localparam logic [MOD400_W-1:0] MOD_300   = MOD400_W'(300);
  localparam logic [ACC_W-1:0]    DIV_400   = ACC_W'(400);

  // Reset date
  localparam logic [DAY_W-1:0]     DAY_RESET   = DAY_W'(1);
  localparam logic [MONTH_W-1:0]   MONTH_RESET = MONTH_W'(0);
  localparam logic [YEAR_BITS-1:0] YEAR_RESET  = YEAR_BITS'(1900);

  // Months
  localparam logic [MONTH_W-1:0] M_JAN = MONTH_W'(0);
  localparam logic [MONTH_W-1:0] M_FEB = MONTH_W'(1);
  localparam logic [MONTH_W-1:0] M_APR = MONTH_W'(3);
  localparam logic [MONTH_W-1:0] M_JUN = MONTH_W'(5);
  localparam logic [MONTH_W-1:0] M_SEP = MONTH_W'(8);
  localparam logic [MONTH_W-1:0] M_NOV = MONTH_W'(10);
  localparam logic [MONTH_W-1:0] M_DEC = MONTH_W'(11);

  // Operation codes
  localparam logic [OP_W-1:0] OP_LOAD = 2'd0;
  localparam logic [OP_W-1:0] OP_ADD  = 2'd1;
  localparam logic [OP_W-1:0] OP_SUB  = 2'd2;
  localparam logic [OP_W-1:0] OP_CMP  = 2'd3;

  // Order codes
  localparam logic [ORDER_W-1:0] ORD_EARLIER = 2'd0;
  localparam logic [ORDER_W-1:0] ORD_EQUAL   = 2'd1;
  localparam logic [ORDER_W-1:0] ORD_LATER   = 2'd2;
  localparam logic [ORDER_W-1:0] ORD_UNUSED  = 2'd3;

  // Sequencer states
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_ADD,
    ST_SUB,
    ST_MOD
  } state_t;

  // Flags of the shared add/subtract unit
  typedef struct packed {
    logic neg;
    logic zero;
  } alu_flags_t;

  // Leap year from the year's residue mod 400
  function automatic logic leap_of(input logic [MOD400_W-1:0] r);
    return (r[1:0] == 2'b00) && (r != MOD_100) && (r != MOD_200) && (r != MOD_300);
  endfunction

  // Month length; months above December count 31 days
  function automatic logic [DAY_W-1:0] month_len(input logic [MONTH_W-1:0] m,
                                                 input logic leap);
    logic [DAY_W-1:0] len;
    len = DAY_W'(31);
    if (m == M_APR || m == M_JUN || m == M_SEP || m == M_NOV) len = DAY_W'(30);
    else if (m == M_FEB) len = leap ? DAY_W'(29) : DAY_W'(28);
    return len;
  endfunction

endpackage

// ===== sv/calendar_date_stepper.sv =====
// ----------------------------------------------------------------------------
// calendar_date_stepper: Gregorian date register with add, subtract, compare
// Holds day, month (0 is January) and year, and runs one operation per start.
// ----------------------------------------------------------------------------
// Raise start for one cycle while busy is low to transfer an operation. The
// result appears for exactly one cycle with out_strobe high and must be taken
// then; the receiver cannot stall it. Compare finishes without leaving idle.
// Load reduces the year modulo 400 one restoring step a cycle for the leap
// rule. Add and subtract walk the date one month a cycle through a single
// shared adder, one month boundary per step; 65535 days is about 2160
// months. A new start is taken in the cycle the strobe shows.
// ----------------------------------------------------------------------------
module calendar_date_stepper
  import cds_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  start,
  output logic                  busy,
  input  logic [OP_W-1:0]       in_operation,
  input  logic [DAY_W-1:0]      in_day,
  input  logic [MONTH_W-1:0]    in_month,
  input  logic [YEAR_BITS-1:0]  in_year,
  input  logic [COUNT_BITS-1:0] in_day_count,
  output logic                  out_strobe,
  output logic [DAY_W-1:0]      out_day,
  output logic [MONTH_W-1:0]    out_month,
  output logic [YEAR_BITS-1:0]  out_year,
  output logic [ORDER_W-1:0]    out_order
);

  state_t state_r, state_nxt;

  logic [DAY_W-1:0]     day_r,   day_nxt;
  logic [MONTH_W-1:0]   month_r, month_nxt;
  logic [YEAR_BITS-1:0] year_r,  year_nxt;
  logic [MOD400_W-1:0]  mod_r,   mod_nxt;
  logic [ORDER_W-1:0]   order_r, order_nxt;
  logic                 strobe_r, strobe_nxt;
  logic signed [ACC_W-1:0] acc_r, acc_nxt;
  logic [K_W-1:0]       k_r, k_nxt;

  logic signed [ACC_W-1:0] alu_a, alu_b, alu_res;
  logic                    alu_sub;
  alu_flags_t              alu_flags;

  logic                 accept;
  logic [MONTH_W-1:0]   next_month, prev_month;
  logic [YEAR_BITS-1:0] next_year, prev_year;
  logic [MOD400_W-1:0]  next_mod, prev_mod;
  logic                 wrap_fwd, wrap_bwd;
  logic                 acc_le_zero;
  logic [ORDER_W-1:0]   cmp_order;

  assign accept      = start && (state_r == ST_IDLE);
  assign acc_le_zero = acc_r[ACC_W-1] || (acc_r == '0);

  // Neighbor months, with year and residue stepping across the year boundary
  always_comb begin
    wrap_fwd   = (month_r >= M_DEC);
    wrap_bwd   = (month_r == M_JAN);
    next_month = wrap_fwd ? M_JAN : month_r + MONTH_W'(1);
    prev_month = wrap_bwd ? M_DEC : month_r - MONTH_W'(1);
    next_year  = year_r;
    next_mod   = mod_r;
    prev_year  = year_r;
    prev_mod   = mod_r;
    if (wrap_fwd) begin
      next_year = year_r + YEAR_BITS'(1);
      if (year_r == '1) next_mod = '0;
      else next_mod = (mod_r == MOD_LAST) ? '0 : mod_r + MOD400_W'(1);
    end
    if (wrap_bwd) begin
      prev_year = year_r - YEAR_BITS'(1);
      if (year_r == '0) prev_mod = MOD_TOP;
      else prev_mod = (mod_r == '0) ? MOD_LAST : mod_r - MOD400_W'(1);
    end
  end

  // Order the held date against the given one
  always_comb begin
    priority if (year_r != in_year)
      cmp_order = (year_r < in_year) ? ORD_EARLIER : ORD_LATER;
    else if (month_r != in_month)
      cmp_order = (month_r < in_month) ? ORD_EARLIER : ORD_LATER;
    else if (day_r != in_day)
      cmp_order = (day_r < in_day) ? ORD_EARLIER : ORD_LATER;
    else
      cmp_order = ORD_EQUAL;
  end

  // Select operands of the shared adder
  always_comb begin
    unique case (state_r)
      ST_IDLE: begin
        alu_a   = ACC_W'(day_r);
        alu_b   = ACC_W'(in_day_count);
        alu_sub = (in_operation == OP_SUB);
      end
      ST_ADD: begin
        alu_a   = acc_r;
        alu_b   = ACC_W'(month_len(month_r, leap_of(mod_r)));
        alu_sub = 1'b1;
      end
      ST_SUB: begin
        alu_a   = acc_r;
        alu_b   = ACC_W'(month_len(prev_month, leap_of(prev_mod)));
        alu_sub = 1'b0;
      end
      ST_MOD: begin
        alu_a   = acc_r;
        alu_b   = DIV_400 << k_r;
        alu_sub = 1'b1;
      end
      default: begin
        alu_a   = acc_r;
        alu_b   = '0;
        alu_sub = 1'b0;
      end
    endcase
  end

  cds_addsub u_addsub (
    .a      (alu_a),
    .b      (alu_b),
    .sub_en (alu_sub),
    .res    (alu_res),
    .flags  (alu_flags)
  );

  // Next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (start) begin
          unique case (in_operation)
            OP_LOAD: state_nxt = ST_MOD;
            OP_ADD:  state_nxt = ST_ADD;
            OP_SUB:  state_nxt = ST_SUB;
            OP_CMP:  state_nxt = ST_IDLE;
            default: state_nxt = ST_IDLE;
          endcase
        end
      end
      ST_ADD: begin
        if (alu_flags.neg || alu_flags.zero) state_nxt = ST_IDLE;
      end
      ST_SUB: begin
        if (!acc_le_zero) state_nxt = ST_IDLE;
      end
      ST_MOD: begin
        if (k_r == '0) state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // Datapath updates and result strobe
  always_comb begin
    day_nxt    = day_r;
    month_nxt  = month_r;
    year_nxt   = year_r;
    mod_nxt    = mod_r;
    order_nxt  = order_r;
    acc_nxt    = acc_r;
    k_nxt      = k_r;
    strobe_nxt = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        if (accept) begin
          order_nxt = ORD_EQUAL;
          unique case (in_operation)
            OP_LOAD: begin
              day_nxt   = in_day;
              month_nxt = in_month;
              year_nxt  = in_year;
              acc_nxt   = ACC_W'(in_year);
              k_nxt     = K_W'(MOD_STEPS - 1);
            end
            OP_ADD, OP_SUB: acc_nxt = alu_res;
            OP_CMP: begin
              order_nxt  = cmp_order;
              strobe_nxt = 1'b1;
            end
            default: order_nxt = ORD_EQUAL;
          endcase
        end
      end
      ST_ADD: begin
        // Advance one month while the day runs past its month
        if (alu_flags.neg || alu_flags.zero) begin
          day_nxt    = acc_r[DAY_W-1:0];
          strobe_nxt = 1'b1;
        end else begin
          acc_nxt   = alu_res;
          month_nxt = next_month;
          year_nxt  = next_year;
          mod_nxt   = next_mod;
        end
      end
      ST_SUB: begin
        // Drop back one month while the day is below one
        if (acc_le_zero) begin
          acc_nxt   = alu_res;
          month_nxt = prev_month;
          year_nxt  = prev_year;
          mod_nxt   = prev_mod;
        end else begin
          day_nxt    = acc_r[DAY_W-1:0];
          strobe_nxt = 1'b1;
        end
      end
      ST_MOD: begin
        // Restoring reduction of the year by 400 times a power of two
        if (!alu_flags.neg) acc_nxt = alu_res;
        k_nxt = k_r - K_W'(1);
        if (k_r == '0) begin
          mod_nxt    = acc_nxt[MOD400_W-1:0];
          strobe_nxt = 1'b1;
        end
      end
      default: strobe_nxt = 1'b0;
    endcase
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= ST_IDLE;
      strobe_r <= 1'b0;
      day_r    <= DAY_RESET;
      month_r  <= MONTH_RESET;
      year_r   <= YEAR_RESET;
      mod_r    <= MOD_RESET;
      order_r  <= ORD_EQUAL;
    end else begin
      state_r  <= state_nxt;
      strobe_r <= strobe_nxt;
      day_r    <= day_nxt;
      month_r  <= month_nxt;
      year_r   <= year_nxt;
      mod_r    <= mod_nxt;
      order_r  <= order_nxt;
    end
  end

  // Working registers
  always_ff @(posedge clk) begin
    acc_r <= acc_nxt;
    k_r   <= k_nxt;
  end

  assign busy       = (state_r != ST_IDLE);
  assign out_strobe = strobe_r;
  assign out_day    = day_r;
  assign out_month  = month_r;
  assign out_year   = year_r;
  assign out_order  = order_r;

endmodule

// ===== sv/cds_addsub.sv =====
// ----------------------------------------------------------------------------
// cds_addsub: shared add/subtract unit
// One signed adder used by every step of the sequencer, with sign and zero
// flags of its result.
// ----------------------------------------------------------------------------
module cds_addsub
  import cds_pkg::*;
(
  input  logic signed [ACC_W-1:0] a,
  input  logic signed [ACC_W-1:0] b,
  input  logic                    sub_en,
  output logic signed [ACC_W-1:0] res,
  output alu_flags_t              flags
);

  // Add or subtract
  assign res = sub_en ? (a - b) : (a + b);

  // Derive flags
  assign flags.neg  = res[ACC_W-1];
  assign flags.zero = (res == '0);

endmodule

// ===== sv/cds_checker.sv =====
// ----------------------------------------------------------------------------
// cds_checker: port-level checks for the calendar date stepper
// Watches the command handshake and the result strobe over time.
// ----------------------------------------------------------------------------
module cds_checker
  import cds_pkg::*;
(
  input logic               clk,
  input logic               rst_n,
  input logic               start,
  input logic               busy,
  input logic [OP_W-1:0]    in_operation,
  input logic               out_strobe,
  input logic [ORDER_W-1:0] out_order
);

  // A result never shows while an operation is still running
  a_strobe_idle: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe |-> !busy)
    else $error("result strobe while busy");

  // A transfer either starts work or yields a result at once
  a_accept_progress: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> (busy || out_strobe))
    else $error("accepted operation made no progress");

  // Finishing a multi-cycle operation delivers its result
  a_done_strobe: assert property (@(posedge clk) disable iff (!rst_n)
    $fell(busy) |-> out_strobe)
    else $error("operation ended without result");

  // Non-compare operations report the neutral order
  a_order_neutral: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy && (in_operation != OP_CMP)) |=> (out_order == ORD_EQUAL))
    else $error("order not neutral for non-compare operation");

  // Order code is always one of the defined values on a result
  a_order_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe |-> (out_order != ORD_UNUSED))
    else $error("undefined order code");

endmodule

bind calendar_date_stepper cds_checker u_cds_checker (
  .clk          (clk),
  .rst_n        (rst_n),
  .start        (start),
  .busy         (busy),
  .in_operation (in_operation),
  .out_strobe   (out_strobe),
  .out_order    (out_order)
);

// ===== bench/calendar_date_stepper_checker.sv =====
// ----------------------------------------------------------------------------
// Calendar date stepper checker
// Watches the operation and result channels of the date stepper. It keeps its
// own copy of the held date, works out the expected result for every
// operation transfer, and compares each strobed result field by field with
// the oldest expected one. It hands the mismatch count and the number of
// results still owed to the test top.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module calendar_date_stepper_checker
  import cds_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  start,
  input  logic                  busy,
  input  logic [OP_W-1:0]       in_operation,
  input  logic [DAY_W-1:0]      in_day,
  input  logic [MONTH_W-1:0]    in_month,
  input  logic [YEAR_BITS-1:0]  in_year,
  input  logic [COUNT_BITS-1:0] in_day_count,
  input  logic                  out_strobe,
  input  logic [DAY_W-1:0]      out_day,
  input  logic [MONTH_W-1:0]    out_month,
  input  logic [YEAR_BITS-1:0]  out_year,
  input  logic [ORDER_W-1:0]    out_order,
  output int                    mismatch_count,
  output int                    dates_in_flight
);

  typedef struct {
    logic [DAY_W-1:0]     day;
    logic [MONTH_W-1:0]   month;
    logic [YEAR_BITS-1:0] year;
    logic [ORDER_W-1:0]   order;
  } date_result_t;

  // Held date as the block should see it
  logic [DAY_W-1:0]     held_day;
  logic [MONTH_W-1:0]   held_month;
  logic [YEAR_BITS-1:0] held_year;

  date_result_t pending_dates[$];

  initial mismatch_count = 0;

  task automatic report_mismatch(input string msg);
    mismatch_count++;
    $display("MISMATCH at %0t ns: %s", $time, msg);
  endtask

  // Days in a month; months past December count 31
  function automatic int days_in(input logic [MONTH_W-1:0] m,
                                 input logic [YEAR_BITS-1:0] y);
    int unsigned yr;
    bit          leap;
    yr   = y;
    leap = ((yr % 4 == 0) && (yr % 100 != 0)) || (yr % 400 == 0);
    if (m == M_APR || m == M_JUN || m == M_SEP || m == M_NOV) return 30;
    if (m == M_FEB) return leap ? 29 : 28;
    return 31;
  endfunction

  // Apply one operation to the held date and return the result it gives
  function automatic date_result_t step_date(input logic [OP_W-1:0]       op,
                                             input logic [DAY_W-1:0]      day,
                                             input logic [MONTH_W-1:0]    month,
                                             input logic [YEAR_BITS-1:0]  year,
                                             input logic [COUNT_BITS-1:0] count);
    int                   d;
    logic [MONTH_W-1:0]   m;
    logic [YEAR_BITS-1:0] y;
    date_result_t         res;
    res.order = ORD_EQUAL;
    m = held_month;
    y = held_year;
    case (op)
      OP_LOAD: begin
        held_day   = day;
        held_month = month;
        held_year  = year;
      end
      OP_ADD: begin
        // walk forward a month at a time until the day fits
        d = int'(held_day) + int'(count);
        while (d > days_in(m, y)) begin
          d -= days_in(m, y);
          if (m >= M_DEC) begin
            m = M_JAN;
            y = y + 1'b1;
          end else begin
            m = m + 1'b1;
          end
        end
        held_day   = DAY_W'(d);
        held_month = m;
        held_year  = y;
      end
      OP_SUB: begin
        // walk backward, borrowing the length of the month stepped into
        d = int'(held_day) - int'(count);
        while (d < 1) begin
          if (m == M_JAN) begin
            m = M_DEC;
            y = y - 1'b1;
          end else begin
            m = m - 1'b1;
          end
          d += days_in(m, y);
        end
        held_day   = DAY_W'(d);
        held_month = m;
        held_year  = y;
      end
      OP_CMP: begin
        // order on year, then month, then day, as stored
        if (held_year != year)
          res.order = (held_year < year) ? ORD_EARLIER : ORD_LATER;
        else if (held_month != month)
          res.order = (held_month < month) ? ORD_EARLIER : ORD_LATER;
        else if (held_day != day)
          res.order = (held_day < day) ? ORD_EARLIER : ORD_LATER;
      end
    endcase
    res.day   = held_day;
    res.month = held_month;
    res.year  = held_year;
    return res;
  endfunction

  // Predict on each operation transfer, then check any strobed result
  always @(posedge clk) begin
    date_result_t want;
    if (!rst_n) begin
      held_day   = DAY_RESET;
      held_month = MONTH_RESET;
      held_year  = YEAR_RESET;
      pending_dates.delete();
      dates_in_flight <= 0;
    end else begin
      if (start && !busy)
        pending_dates.push_back(step_date(in_operation, in_day, in_month, in_year,
                                          in_day_count));
      if (out_strobe) begin
        if (pending_dates.size() == 0) begin
          report_mismatch($sformatf("unexpected result day %0d month %0d year %0d order %0d",
                                    out_day, out_month, out_year, out_order));
        end else begin
          want = pending_dates.pop_front();
          if (out_day !== want.day || out_month !== want.month ||
              out_year !== want.year || out_order !== want.order)
            report_mismatch($sformatf({"got day %0d month %0d year %0d order %0d, ",
                                       "want day %0d month %0d year %0d order %0d"},
                                      out_day, out_month, out_year, out_order,
                                      want.day, want.month, want.year, want.order));
        end
      end
      dates_in_flight <= pending_dates.size();
    end
  end

endmodule

// ===== bench/calendar_date_stepper_test.sv =====
// ----------------------------------------------------------------------------
// Calendar date stepper test
// Drives load, add, subtract and compare operations into the date stepper:
// a directed run over leap years, year wrap and out-of-range dates, then
// random operations in phases with and without sender idling. The checker
// beside the block predicts and compares; this top gives the verdict.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module calendar_date_stepper_test;
  import cds_pkg::*;

  localparam logic [MONTH_W-1:0]   MON_MAR  = MONTH_W'(2);
  localparam logic [MONTH_W-1:0]   MON_TOP  = MONTH_W'(15);
  localparam logic [YEAR_BITS-1:0] YEAR_TOP = '1;
  localparam int                   DRAIN_CYCLES = 50;

  logic                  clk;
  logic                  rst_n        = 1'b0;
  logic                  start        = 1'b0;
  logic [OP_W-1:0]       in_operation = OP_LOAD;
  logic [DAY_W-1:0]      in_day       = '0;
  logic [MONTH_W-1:0]    in_month     = '0;
  logic [YEAR_BITS-1:0]  in_year      = '0;
  logic [COUNT_BITS-1:0] in_day_count = '0;
  logic                  busy;
  logic                  out_strobe;
  logic [DAY_W-1:0]      out_day;
  logic [MONTH_W-1:0]    out_month;
  logic [YEAR_BITS-1:0]  out_year;
  logic [ORDER_W-1:0]    out_order;
  int                    mismatch_count;
  int                    dates_in_flight;

  int idle_pct = 0;
  // sender idle percentage per random phase; the receiver cannot stall
  int idle_by_phase[4] = '{0, 56, 0, 23};

  calendar_date_stepper dut (.*);

  calendar_date_stepper_checker date_check (.*);

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Bound the run
  initial begin
    #30_000_000;
    $display("DONE: errors detected");
    $finish;
  end

  // Present one operation, idling first at random, and hold it until transfer
  task automatic issue_op(input logic [OP_W-1:0]       op,
                          input logic [DAY_W-1:0]      day,
                          input logic [MONTH_W-1:0]    month,
                          input logic [YEAR_BITS-1:0]  year,
                          input logic [COUNT_BITS-1:0] count);
    while ($urandom_range(99) < idle_pct) begin
      start <= 1'b0;
      @(posedge clk);
    end
    start        <= 1'b1;
    in_operation <= op;
    in_day       <= day;
    in_month     <= month;
    in_year      <= year;
    in_day_count <= count;
    @(posedge clk);
    while (busy) @(posedge clk);
  endtask

  function automatic logic [DAY_W-1:0] rand_day();
    if ($urandom_range(99) < 8) return '0;
    return DAY_W'($urandom_range(1, 31));
  endfunction

  function automatic logic [MONTH_W-1:0] rand_month();
    if ($urandom_range(99) < 10) return MONTH_W'($urandom_range(12, 15));
    return MONTH_W'($urandom_range(0, 11));
  endfunction

  function automatic logic [YEAR_BITS-1:0] rand_year();
    int r;
    r = $urandom_range(99);
    if (r < 40) return YEAR_BITS'($urandom_range(1580, 2500));
    if (r < 80) return YEAR_BITS'($urandom_range(0, int'(YEAR_TOP)));
    if (r < 90) return YEAR_BITS'($urandom_range(0, 3));
    return YEAR_TOP - YEAR_BITS'($urandom_range(0, 3));
  endfunction

  // Mostly short steps, some full range, some at the ends
  function automatic logic [COUNT_BITS-1:0] rand_count();
    int r;
    r = $urandom_range(99);
    if (r < 50) return COUNT_BITS'($urandom_range(0, 400));
    if (r < 80) return COUNT_BITS'($urandom_range(0, (1 << COUNT_BITS) - 1));
    if (r < 90) return COUNT_BITS'($urandom_range(0, 2000));
    return $urandom_range(1) ? '1 : '0;
  endfunction

  task automatic send_random_item();
    logic [DAY_W-1:0]     d;
    logic [MONTH_W-1:0]   m;
    logic [YEAR_BITS-1:0] y;
    int                   pick;
    pick = $urandom_range(99);
    d = rand_day();
    m = rand_month();
    y = rand_year();
    if (pick < 20) begin
      issue_op(OP_LOAD, d, m, y, rand_count());
    end else if (pick < 42) begin
      issue_op(OP_ADD, d, m, y, rand_count());
    end else if (pick < 64) begin
      issue_op(OP_SUB, d, m, y, rand_count());
    end else if (pick < 80) begin
      issue_op(OP_CMP, d, m, y, rand_count());
    end else begin
      // load a date, then compare against it or a neighbor in one field
      issue_op(OP_LOAD, d, m, y, rand_count());
      case ($urandom_range(3))
        0: d = $urandom_range(1) ? d + 1'b1 : d - 1'b1;
        1: m = $urandom_range(1) ? m + 1'b1 : m - 1'b1;
        2: y = $urandom_range(1) ? y + 1'b1 : y - 1'b1;
        default: ;
      endcase
      issue_op(OP_CMP, d, m, y, rand_count());
    end
  endtask

  initial begin
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;

    // reset date
    issue_op(OP_CMP,  5'd1,  M_JAN, 14'd1900, '0);
    // year wrap both ways, all-ones fields
    issue_op(OP_LOAD, 5'd31, M_DEC, YEAR_TOP, '1);
    issue_op(OP_ADD,  '0,    M_JAN, '0, 16'd1);
    issue_op(OP_SUB,  '1,    MON_TOP, YEAR_TOP, 16'd1);
    // century rule: 1900 and 2100 common, 2000 leap
    issue_op(OP_LOAD, 5'd28, M_FEB, 14'd1900, '0);
    issue_op(OP_ADD,  '0,    M_JAN, '0, 16'd1);
    issue_op(OP_LOAD, 5'd28, M_FEB, 14'd2000, '0);
    issue_op(OP_ADD,  '0,    M_JAN, '0, 16'd1);
    issue_op(OP_LOAD, 5'd1,  MON_MAR, 14'd2100, '0);
    issue_op(OP_SUB,  '0,    M_JAN, '0, 16'd1);
    // backward across New Year
    issue_op(OP_LOAD, 5'd1,  M_JAN, 14'd2001, '0);
    issue_op(OP_SUB,  '0,    M_JAN, '0, 16'd1);
    // day past month end: subtract keeps it, add normalizes forward
    issue_op(OP_LOAD, 5'd31, M_FEB, 14'd2001, '0);
    issue_op(OP_SUB,  '0,    M_JAN, '0, '0);
    issue_op(OP_ADD,  '0,    M_JAN, '0, '0);
    // day zero: zero add keeps it, zero subtract borrows back a year
    issue_op(OP_LOAD, '0,    M_JAN, '0, '0);
    issue_op(OP_ADD,  '0,    M_JAN, '0, '0);
    issue_op(OP_SUB,  '0,    M_JAN, '0, '0);
    // month above December: back steps down, forward rolls the year
    issue_op(OP_LOAD, 5'd20, MON_TOP, 14'd500, '0);
    issue_op(OP_SUB,  '0,    M_JAN, '0, 16'd40);
    issue_op(OP_ADD,  '0,    M_JAN, '0, 16'd80);
    // longest walks
    issue_op(OP_LOAD, 5'd15, M_JUN, 14'd2020, '0);
    issue_op(OP_ADD,  '0,    M_JAN, '0, '1);
    issue_op(OP_SUB,  '0,    M_JAN, '0, '1);
    issue_op(OP_CMP,  5'd15, M_JUN, 14'd2020, '0);

    // random operations, phase by phase
    foreach (idle_by_phase[p]) begin
      idle_pct = idle_by_phase[p];
      repeat (55) send_random_item();
    end

    // drain
    start <= 1'b0;
    @(posedge clk);
    while (dates_in_flight != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatch_count == 0)
      $display("DONE: 0 errors");
    else
      $display("DONE: errors detected");
    $finish;
  end

endmodule

// ===== sim.f =====
sv/cds_pkg.sv
sv/cds_addsub.sv
sv/calendar_date_stepper.sv
sv/cds_checker.sv
bench/calendar_date_stepper_checker.sv
bench/calendar_date_stepper_test.sv
